// ===== hdl/ps2_mouse_packet_cursor_top_defines.svh =====
// Assertion macros shared by the PS/2 mouse cursor checker.
// Depends on nothing; included by files that assert.
`ifndef PS2_MOUSE_PACKET_CURSOR_TOP_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_TOP_DEFINES_SVH

// Property checked every clock outside of reset.
`define PS2MPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked every clock, reset included.
`define PS2MPC_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ps2mpc_pkg.sv =====
// Types and constants for the PS/2 mouse packet cursor block.
// No dependencies.
package ps2mpc_pkg;

    localparam int RX_W     = 8;
    localparam int LIMIT_W  = 8;
    localparam int BTN_W    = 3;
    localparam int OUT_C_W  = 8;
    localparam int TDATA_W  = 24;
    localparam int SYNC_BIT = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [LIMIT_W-1:0] RESET_MAX_COL = 8'd79;
    localparam logic [LIMIT_W-1:0] RESET_MAX_ROW = 8'd24;
    localparam logic [7:0]         RESET_COL     = 8'd40;
    localparam logic [7:0]         RESET_ROW     = 8'd12;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLUMN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROW    = 2'd1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_XMOVE  = 2'd1,
        PH_YMOVE  = 2'd2
    } t_phase;

    typedef struct packed {
        logic sync_drop;
        logic packet_done;
    } t_flags;

endpackage

// ===== hdl/ps2mpc_step.sv =====
// Per-byte packet assembly, cursor add and clamp for the PS/2 mouse block.
// Depends on ps2mpc_pkg.
module ps2mpc_step #(
    parameter int COORD_WIDTH = 8
) (
    input  ps2mpc_pkg::t_phase                i_phase,
    input  logic [ps2mpc_pkg::RX_W-1:0]       i_header,
    input  logic [ps2mpc_pkg::RX_W-1:0]       i_xmove,
    input  logic [COORD_WIDTH-1:0]            i_pos_col,
    input  logic [COORD_WIDTH-1:0]            i_pos_row,
    input  logic [ps2mpc_pkg::BTN_W-1:0]      i_buttons,
    input  logic [ps2mpc_pkg::LIMIT_W-1:0]    i_max_col,
    input  logic [ps2mpc_pkg::LIMIT_W-1:0]    i_max_row,
    input  logic [ps2mpc_pkg::RX_W-1:0]       i_byte,
    output ps2mpc_pkg::t_phase                o_phase,
    output logic [ps2mpc_pkg::RX_W-1:0]       o_header,
    output logic [ps2mpc_pkg::RX_W-1:0]       o_xmove,
    output logic [COORD_WIDTH-1:0]            o_pos_col,
    output logic [COORD_WIDTH-1:0]            o_pos_row,
    output logic [ps2mpc_pkg::BTN_W-1:0]      o_buttons,
    output ps2mpc_pkg::t_flags                o_flags
);

    localparam int SW = COORD_WIDTH + 2;

    logic signed [SW-1:0] dx, dy, sum_col, sum_row, lim_col, lim_row;
    logic [COORD_WIDTH-1:0] clamp_col, clamp_row;
    logic sync_ok;

    assign sync_ok = i_byte[ps2mpc_pkg::SYNC_BIT];

    assign dx      = SW'($signed(i_xmove));
    assign dy      = SW'($signed(i_byte));
    assign sum_col = $signed(SW'(i_pos_col)) + dx;
    assign sum_row = $signed(SW'(i_pos_row)) - dy;
    assign lim_col = $signed(SW'(i_max_col));
    assign lim_row = $signed(SW'(i_max_row));

    always_comb begin
        if (sum_col < 0) begin
            clamp_col = '0;
        end else if (sum_col > lim_col) begin
            clamp_col = COORD_WIDTH'(i_max_col);
        end else begin
            clamp_col = sum_col[COORD_WIDTH-1:0];
        end
        if (sum_row < 0) begin
            clamp_row = '0;
        end else if (sum_row > lim_row) begin
            clamp_row = COORD_WIDTH'(i_max_row);
        end else begin
            clamp_row = sum_row[COORD_WIDTH-1:0];
        end
    end

    // next phase
    always_comb begin
        unique case (i_phase)
            ps2mpc_pkg::PH_HEADER: o_phase = sync_ok ? ps2mpc_pkg::PH_XMOVE
                                                     : ps2mpc_pkg::PH_HEADER;
            ps2mpc_pkg::PH_XMOVE:  o_phase = ps2mpc_pkg::PH_YMOVE;
            default:               o_phase = ps2mpc_pkg::PH_HEADER;
        endcase
    end

    // data path and flags; the unused phase code acts as the third byte
    always_comb begin
        o_header  = i_header;
        o_xmove   = i_xmove;
        o_pos_col = i_pos_col;
        o_pos_row = i_pos_row;
        o_buttons = i_buttons;
        o_flags   = '0;
        unique case (i_phase)
            ps2mpc_pkg::PH_HEADER: begin
                if (sync_ok) begin
                    o_header = i_byte;
                end else begin
                    o_flags.sync_drop = 1'b1;
                end
            end
            ps2mpc_pkg::PH_XMOVE: begin
                o_xmove = i_byte;
            end
            default: begin
                o_pos_col = clamp_col;
                o_pos_row = clamp_row;
                o_buttons = i_header[ps2mpc_pkg::BTN_W-1:0];
                o_flags.packet_done = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/ps2mpc_out_reg.sv =====
// Result register of the PS/2 mouse block; decouples the two stream sides.
// Depends on ps2mpc_pkg.
module ps2mpc_out_reg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic [ps2mpc_pkg::TDATA_W-1:0]     i_tdata,
    input  ps2mpc_pkg::t_flags                 i_tuser,
    input  logic                               i_m_tready,
    output logic                               o_can_load,
    output logic                               o_m_tvalid,
    output logic [ps2mpc_pkg::TDATA_W-1:0]     o_m_tdata,
    output ps2mpc_pkg::t_flags                 o_m_tuser
);

    logic                           r_valid;
    logic [ps2mpc_pkg::TDATA_W-1:0] r_tdata;
    ps2mpc_pkg::t_flags             r_tuser;

    assign o_can_load = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_tdata <= i_tdata;
            r_tuser <= i_tuser;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;

endmodule

// ===== hdl/ps2_mouse_packet_cursor_top.sv =====
// PS/2 mouse three-byte packet decoder driving a saturating text cursor.
// Depends on ps2mpc_pkg, ps2mpc_step and ps2mpc_out_reg.
//
// Use:
//   Slave stream (i_s_*) takes one received mouse byte per transfer.
//   Master stream (o_m_*) returns exactly one result per byte: cursor
//   column and row, buttons of the last full packet, and two flags
//   (packet completed, header byte dropped for lack of the sync bit).
//   Config channel (i_cfg_*) writes max_column (index 0) and max_row
//   (index 1); other indexes are ignored. o_cfg_ready is always high.
// Timing:
//   The result is registered: o_m_tvalid rises in the cycle after the
//   input transfer. One byte per cycle is sustained while i_m_tready is
//   high; the single result register allows it. A byte is taken while a
//   result waits if that result leaves in the same cycle.
// Reset:
//   Synchronous, active low. Cursor returns to column 40, row 12, buttons
//   clear, limits return to 79 and 24, the packet restarts at byte one.
// Stall:
//   While i_m_tready is low with a result held, o_s_tready drops and the
//   result stays unchanged.
module ps2_mouse_packet_cursor_top #(
    parameter int COORD_WIDTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [ps2mpc_pkg::RX_W-1:0]         i_s_tdata,   // [7:0] rx_byte
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [7:0] cursor_col, [15:8] cursor_row, [18:16] button_bits, [23:19] zero
    output logic [ps2mpc_pkg::TDATA_W-1:0]      o_m_tdata,
    output logic [1:0]                          o_m_tuser,   // [0] packet_done, [1] sync_drop
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ps2mpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ps2mpc_pkg::LIMIT_W-1:0]      i_cfg_data
);

    ps2mpc_pkg::t_phase                r_phase, n_phase;
    logic [ps2mpc_pkg::RX_W-1:0]       r_header, n_header;
    logic [ps2mpc_pkg::RX_W-1:0]       r_xmove, n_xmove;
    logic [COORD_WIDTH-1:0]            r_pos_col, n_pos_col;
    logic [COORD_WIDTH-1:0]            r_pos_row, n_pos_row;
    logic [ps2mpc_pkg::BTN_W-1:0]      r_buttons, n_buttons;
    logic [ps2mpc_pkg::LIMIT_W-1:0]    r_max_col, r_max_row;
    ps2mpc_pkg::t_flags                step_flags, out_flags;
    logic [ps2mpc_pkg::TDATA_W-1:0]    step_tdata;
    logic                              accept;

    assign accept      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_col <= ps2mpc_pkg::RESET_MAX_COL;
            r_max_row <= ps2mpc_pkg::RESET_MAX_ROW;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == ps2mpc_pkg::CFG_MAX_COLUMN) begin
                r_max_col <= i_cfg_data;
            end
            if (i_cfg_index == ps2mpc_pkg::CFG_MAX_ROW) begin
                r_max_row <= i_cfg_data;
            end
        end
    end

    ps2mpc_step #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_step (
        .i_phase  (r_phase),
        .i_header (r_header),
        .i_xmove  (r_xmove),
        .i_pos_col(r_pos_col),
        .i_pos_row(r_pos_row),
        .i_buttons(r_buttons),
        .i_max_col(r_max_col),
        .i_max_row(r_max_row),
        .i_byte   (i_s_tdata),
        .o_phase  (n_phase),
        .o_header (n_header),
        .o_xmove  (n_xmove),
        .o_pos_col(n_pos_col),
        .o_pos_row(n_pos_row),
        .o_buttons(n_buttons),
        .o_flags  (step_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ps2mpc_pkg::PH_HEADER;
            r_header  <= '0;
            r_xmove   <= '0;
            r_pos_col <= COORD_WIDTH'(ps2mpc_pkg::RESET_COL);
            r_pos_row <= COORD_WIDTH'(ps2mpc_pkg::RESET_ROW);
            r_buttons <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_header  <= n_header;
            r_xmove   <= n_xmove;
            r_pos_col <= n_pos_col;
            r_pos_row <= n_pos_row;
            r_buttons <= n_buttons;
        end
    end

    assign step_tdata = {5'b0, n_buttons,
                         ps2mpc_pkg::OUT_C_W'(n_pos_row),
                         ps2mpc_pkg::OUT_C_W'(n_pos_col)};

    ps2mpc_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (i_s_tvalid),
        .i_tdata   (step_tdata),
        .i_tuser   (step_flags),
        .i_m_tready(i_m_tready),
        .o_can_load(o_s_tready),
        .o_m_tvalid(o_m_tvalid),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (out_flags)
    );

    assign o_m_tuser = out_flags;

endmodule

// ===== hdl/ps2mpc_checker.sv =====
// Port-level checks for the PS/2 mouse cursor block, bound to the top level.
// Depends on ps2mpc_pkg and ps2_mouse_packet_cursor_top_defines.svh.
`include "ps2_mouse_packet_cursor_top_defines.svh"

module ps2mpc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_s_tready,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [ps2mpc_pkg::TDATA_W-1:0]      o_m_tdata,
    input logic [1:0]                          o_m_tuser
);

    `PS2MPC_ASSERT_ALL(a_reset_empty, i_clk,
        !i_rst_n |=> !o_m_tvalid,
        "result valid after reset")

    `PS2MPC_ASSERT(a_flags_excl, i_clk, i_rst_n,
        o_m_tvalid |-> (o_m_tuser != 2'b11),
        "done and drop both set")

    `PS2MPC_ASSERT(a_ready_rule, i_clk, i_rst_n,
        o_s_tready == (!o_m_tvalid || i_m_tready),
        "input ready does not follow output side")

    `PS2MPC_ASSERT(a_stall_hold, i_clk, i_rst_n,
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)),
        "stalled result changed")

endmodule

bind ps2_mouse_packet_cursor_top ps2mpc_checker u_ps2mpc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser)
);
